// ----- rtl/hlf_pkg.sv -----
// Shared types and constants for the Holt linear forecaster.
// Holds configuration indexes, reset values and the controller/datapath command types.
// No dependencies.
`default_nettype none

package hlf_pkg;

  localparam int FIELD_W   = 32;
  localparam int WEIGHT_W  = 17;
  localparam int HORIZON_W = 7;
  localparam int STEP_W    = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HORIZON = 2'd2;

  localparam logic [WEIGHT_W-1:0]  ONE_Q16     = 17'h10000;
  localparam logic [WEIGHT_W-1:0]  ALPHA_RST   = 17'd19661;
  localparam logic [WEIGHT_W-1:0]  BETA_RST    = 17'd6554;
  localparam logic [HORIZON_W-1:0] HORIZON_RST = 7'd8;
  localparam int                   ROUND_Q16   = 32768;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_FIRST,
    OP_SECOND,
    OP_LOAD,
    OP_DIFF_L,
    OP_DIFF_T,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_APPLY_L,
    OP_APPLY_T,
    OP_FINIT,
    OP_EMIT,
    OP_SHORT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   sel_trend;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic last_step;
  } dp_sts_t;

endpackage

`default_nettype wire

// ----- rtl/hlf_ctrl.sv -----
// Sequencer for the Holt linear forecaster: input handshake, update steps, forecast run.
// Drives datapath commands; depends on hlf_pkg.
`default_nettype none

module hlf_ctrl import hlf_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_series_end,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHORT,
    S_DIFF,
    S_MLO,
    S_MHI,
    S_APPLY,
    S_FINIT,
    S_EMIT
  } state_t;

  state_t     state_r;
  logic [1:0] seen_r;
  logic       phase_r;
  logic       last_r;
  logic       accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd.op        = OP_NONE;
    cmd.sel_trend = phase_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (seen_r)
            2'd0:    cmd.op = OP_FIRST;
            2'd1:    cmd.op = OP_SECOND;
            default: cmd.op = OP_LOAD;
          endcase
        end
      end
      S_SHORT: begin
        if (sts.out_free) cmd.op = OP_SHORT;
      end
      S_DIFF:  cmd.op = phase_r ? OP_DIFF_T : OP_DIFF_L;
      S_MLO:   cmd.op = OP_MUL_LO;
      S_MHI:   cmd.op = OP_MUL_HI;
      S_APPLY: cmd.op = phase_r ? OP_APPLY_T : OP_APPLY_L;
      S_FINIT: cmd.op = OP_FINIT;
      S_EMIT: begin
        if (sts.out_free) cmd.op = OP_EMIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      seen_r  <= 2'd0;
      phase_r <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            last_r  <= in_series_end;
            phase_r <= 1'b0;
            unique case (seen_r)
              2'd0: begin
                seen_r  <= 2'd1;
                state_r <= in_series_end ? S_SHORT : S_IDLE;
              end
              2'd1: begin
                seen_r  <= 2'd2;
                state_r <= S_DIFF;
              end
              default: state_r <= S_DIFF;
            endcase
          end
        end
        S_SHORT: begin
          if (sts.out_free) begin
            seen_r  <= 2'd0;
            state_r <= S_IDLE;
          end
        end
        S_DIFF:  state_r <= S_MLO;
        S_MLO:   state_r <= S_MHI;
        S_MHI:   state_r <= S_APPLY;
        S_APPLY: begin
          if (!phase_r) begin
            phase_r <= 1'b1;
            state_r <= S_DIFF;
          end else begin
            state_r <= last_r ? S_FINIT : S_IDLE;
          end
        end
        S_FINIT: state_r <= S_EMIT;
        S_EMIT: begin
          if (sts.out_free && sts.last_step) begin
            seen_r  <= 2'd0;
            state_r <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/hlf_dp.sv -----
// Datapath for the Holt linear forecaster: level/trend state, shared weight multiplier,
// forecast accumulator and output register. Depends on hlf_pkg.
`default_nettype none

module hlf_dp import hlf_pkg::*; #(
  parameter int MAX_HORIZON = 64,
  parameter int PRICE_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dp_cmd_t              cmd,
  output dp_sts_t              sts,
  input  logic [FIELD_W-1:0]   in_price,
  input  logic [WEIGHT_W-1:0]  alpha,
  input  logic [WEIGHT_W-1:0]  beta,
  input  logic [HORIZON_W-1:0] horizon,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [FIELD_W-1:0]   out_forecast,
  output logic [STEP_W-1:0]    out_step_ahead,
  output logic                 out_final_res,
  output logic                 out_status
);

  localparam int SW  = PRICE_WIDTH + 2;
  localparam int SSW = SW + 1;
  localparam int DW  = PRICE_WIDTH + 4;
  localparam int XW  = DW + 2;
  localparam int MW  = DW + 1;
  localparam int LOW = DW / 2;
  localparam int HIW = DW - LOW;
  localparam int BW  = LOW + 1;
  localparam int PPW = WEIGHT_W + 1 + BW;
  localparam int TW  = WEIGHT_W + 1 + DW + 1;
  localparam int AW  = SW + 8;
  localparam int HCW = 9;

  localparam logic signed [SW-1:0] STATE_MAX   = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] STATE_MIN   = {1'b1, {(SW-1){1'b0}}};
  localparam logic signed [AW-1:0] PRICE_MAX_A =
    {{(AW-PRICE_WIDTH){1'b0}}, {PRICE_WIDTH{1'b1}}};
  localparam logic [HCW-1:0]       MAX_H       = HCW'(MAX_HORIZON);

  function automatic logic signed [SW-1:0] sat_state(input logic signed [XW-1:0] v);
    logic signed [SW-1:0] r;
    if (v > XW'(STATE_MAX)) r = STATE_MAX;
    else if (v < XW'(STATE_MIN)) r = STATE_MIN;
    else r = v[SW-1:0];
    return r;
  endfunction

  logic [PRICE_WIDTH+FIELD_W-1:0] price_wide;
  logic signed [SW-1:0]           price_in;
  logic [WEIGHT_W-1:0]            alpha_eff;
  logic [WEIGHT_W-1:0]            beta_eff;
  logic [WEIGHT_W-1:0]            w_sel;
  logic signed [HIW-1:0]          d_hi;
  logic signed [BW-1:0]           mul_b;
  logic signed [PPW-1:0]          mul_p;
  logic signed [TW-1:0]           tot;
  logic signed [TW-1:0]           tot_sh;
  logic signed [MW-1:0]           m_q;
  logic signed [SSW-1:0]          sum_s;
  logic [HORIZON_W-1:0]           h_nz;
  logic [HORIZON_W-1:0]           h_eff;
  logic [PRICE_WIDTH-1:0]         fc_pw;
  logic [PRICE_WIDTH+FIELD_W-1:0] fc_wide;
  logic                           out_free;

  logic signed [SW-1:0]   price_r;
  logic signed [SW-1:0]   level_r;
  logic signed [SW-1:0]   trend_r;
  logic signed [SW-1:0]   prev_r;
  logic signed [SSW-1:0]  s_r;
  logic signed [DW-1:0]   d_r;
  logic signed [PPW-1:0]  plo_r;
  logic signed [PPW-1:0]  phi_r;
  logic signed [AW-1:0]   acc_r;
  logic [STEP_W-1:0]      k_r;
  logic                   out_valid_r;
  logic [FIELD_W-1:0]     out_forecast_r;
  logic [STEP_W-1:0]      out_step_r;
  logic                   out_final_r;
  logic                   out_status_r;

  assign price_wide = {{PRICE_WIDTH{1'b0}}, in_price};
  assign price_in   = $signed({2'b00, price_wide[PRICE_WIDTH-1:0]});

  assign alpha_eff = (alpha > ONE_Q16) ? ONE_Q16 : alpha;
  assign beta_eff  = (beta > ONE_Q16) ? ONE_Q16 : beta;
  assign w_sel     = cmd.sel_trend ? beta_eff : alpha_eff;

  assign d_hi  = d_r[DW-1:LOW];
  assign mul_b = (cmd.op == OP_MUL_HI) ? BW'(d_hi) : $signed({1'b0, d_r[LOW-1:0]});
  assign mul_p = $signed({1'b0, w_sel}) * mul_b;

  assign tot    = (TW'(phi_r) <<< LOW) + TW'(plo_r) + TW'(ROUND_Q16);
  assign tot_sh = tot >>> 16;
  assign m_q    = tot_sh[MW-1:0];

  assign sum_s = SSW'(level_r) + SSW'(trend_r);

  assign h_nz  = (horizon == '0) ? HORIZON_W'(1) : horizon;
  assign h_eff = ({{(HCW-HORIZON_W){1'b0}}, h_nz} > MAX_H) ? MAX_H[HORIZON_W-1:0] : h_nz;

  always_comb begin
    if (acc_r < 0) fc_pw = '0;
    else if (acc_r > PRICE_MAX_A) fc_pw = '1;
    else fc_pw = acc_r[PRICE_WIDTH-1:0];
  end
  assign fc_wide = {{FIELD_W{1'b0}}, fc_pw};

  assign out_free      = !out_valid_r || out_ready;
  assign sts.out_free  = out_free;
  assign sts.last_step = (k_r == h_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_EMIT || cmd.op == OP_SHORT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_FIRST: begin
        level_r <= price_in;
        trend_r <= '0;
      end
      OP_SECOND: begin
        price_r <= price_in;
        trend_r <= sat_state(XW'(price_in) - XW'(level_r));
      end
      OP_LOAD: price_r <= price_in;
      OP_DIFF_L: begin
        s_r <= sum_s;
        d_r <= DW'(price_r) - DW'(sum_s);
      end
      OP_DIFF_T: d_r <= DW'(level_r) - DW'(prev_r) - DW'(trend_r);
      OP_MUL_LO: plo_r <= mul_p;
      OP_MUL_HI: phi_r <= mul_p;
      OP_APPLY_L: begin
        prev_r  <= level_r;
        level_r <= sat_state(XW'(s_r) + XW'(m_q));
      end
      OP_APPLY_T: trend_r <= sat_state(XW'(trend_r) + XW'(m_q));
      OP_FINIT: begin
        acc_r <= AW'(level_r) + AW'(trend_r);
        k_r   <= STEP_W'(1);
      end
      OP_EMIT: begin
        out_forecast_r <= fc_wide[FIELD_W-1:0];
        out_step_r     <= k_r;
        out_final_r    <= (k_r == h_eff);
        out_status_r   <= 1'b0;
        acc_r          <= acc_r + AW'(trend_r);
        k_r            <= k_r + 1'b1;
      end
      OP_SHORT: begin
        out_forecast_r <= '0;
        out_step_r     <= '0;
        out_final_r    <= 1'b1;
        out_status_r   <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_forecast   = out_forecast_r;
  assign out_step_ahead = out_step_r;
  assign out_final_res  = out_final_r;
  assign out_status     = out_status_r;

endmodule

`default_nettype wire

// ----- rtl/holt_linear_forecaster_unit.sv -----
// Top level of the Holt linear forecaster: configuration registers, sequencer and datapath.
// Depends on hlf_pkg, hlf_ctrl and hlf_dp.
//
// Usage: price samples (unsigned Q16.16) enter on the in_ channel, one item per sample,
// with in_series_end high on the last sample of a series. Forecasts leave on the out_
// channel. alpha, beta and horizon are to be written on the cfg_ port only while the block
// is idle; the block itself does not enforce this. Operation: the first sample of a series
// sets the level and a zero trend (if it also ends the series, one too-short result follows
// once the output register is free). Each later sample runs two Holt updates, both through
// one shared weight multiplier that forms each weighted product from two half-width partial
// products. At the end of a series the first forecast is loaded, then forecasts follow at
// one per cycle unless the out_ channel stalls, horizon of them (zero counts as one, capped
// at MAX_HORIZON), the last with out_final_res high. A single output register sits between
// the forecast generator and the out_ channel; while it is stalled the generator holds.
// After the last forecast is loaded the block takes the next item even if that forecast
// has not yet been taken. Reset (synchronous, active low) clears the series state and the
// output valid flag and loads the default weights and horizon.
`default_nettype none

module holt_linear_forecaster_unit import hlf_pkg::*; #(
  parameter int MAX_HORIZON = 64,
  parameter int PRICE_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [FIELD_W-1:0]   in_price,
  input  logic                 in_series_end,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [FIELD_W-1:0]   out_forecast,
  output logic [STEP_W-1:0]    out_step_ahead,
  output logic                 out_final_res,
  output logic                 out_status,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WEIGHT_W-1:0]  cfg_wdata
);

  logic [WEIGHT_W-1:0]  alpha_r;
  logic [WEIGHT_W-1:0]  beta_r;
  logic [HORIZON_W-1:0] horizon_r;
  dp_cmd_t              cmd;
  dp_sts_t              sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r   <= ALPHA_RST;
      beta_r    <= BETA_RST;
      horizon_r <= HORIZON_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_ALPHA:   alpha_r   <= cfg_wdata;
        CFG_BETA:    beta_r    <= cfg_wdata;
        CFG_HORIZON: horizon_r <= cfg_wdata[HORIZON_W-1:0];
        default: begin
        end
      endcase
    end
  end

  hlf_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_series_end (in_series_end),
    .in_ready      (in_ready),
    .sts           (sts),
    .cmd           (cmd)
  );

  hlf_dp #(
    .MAX_HORIZON (MAX_HORIZON),
    .PRICE_WIDTH (PRICE_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_price       (in_price),
    .alpha          (alpha_r),
    .beta           (beta_r),
    .horizon        (horizon_r),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_forecast   (out_forecast),
    .out_step_ahead (out_step_ahead),
    .out_final_res  (out_final_res),
    .out_status     (out_status)
  );

endmodule

`default_nettype wire
